### design/periodic_task_dispatcher_top_defines.svh
// Assertion macros for the periodic task dispatcher.
`ifndef PERIODIC_TASK_DISPATCHER_TOP_DEFINES_SVH
`define PERIODIC_TASK_DISPATCHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptd assertion failed");

// Next-cycle implication, disabled during reset.
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptd assertion failed");

`endif

### design/ptd_pkg.sv
// Shared types and constants for the periodic task dispatcher.
package ptd_pkg;

    localparam int TASK_SLOTS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_SUSPEND = 2'd1,
        CMD_RESUME  = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    localparam logic KIND_STATUS   = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_BAD_ID = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              do_cmd;
        logic              do_tick;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              flush;
    } dp_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic pending;
    } dp_stat_t;

endpackage

### design/ptd_ctrl.sv
// Sequencer for command handling and the per-tick slot scan.
module ptd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        cmd,
    input  ptd_pkg::dp_stat_t stat,
    output logic              busy,
    output ptd_pkg::dp_ctrl_t ctrl
);

    ptd_pkg::state_t           state_reg, state_next;
    logic [ptd_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic                       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptd_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        busy         = (state_reg != ptd_pkg::ST_IDLE);
        accept       = start && (state_reg == ptd_pkg::ST_IDLE);
        ctrl.do_cmd  = accept && (cmd != ptd_pkg::CMD_TICK);
        ctrl.do_tick = accept && (cmd == ptd_pkg::CMD_TICK);
        ctrl.rd_en   = 1'b0;
        ctrl.rd_addr = idx_reg;
        ctrl.flush   = 1'b0;
        case (state_reg)
            ptd_pkg::ST_IDLE:
            begin
                if (ctrl.do_tick)
                begin
                    state_next = ptd_pkg::ST_SCAN;
                    idx_next   = '0;
                end
            end
            ptd_pkg::ST_SCAN:
            begin
                ctrl.rd_en = 1'b1;
                if (idx_reg == ptd_pkg::SLOT_W'(ptd_pkg::TASK_SLOTS - 1))
                    state_next = ptd_pkg::ST_DRAIN;
                else
                    idx_next = idx_reg + ptd_pkg::SLOT_W'(1);
            end
            // last slot read is evaluated here
            ptd_pkg::ST_DRAIN:
                state_next = ptd_pkg::ST_FLUSH;
            ptd_pkg::ST_FLUSH:
            begin
                ctrl.flush = stat.pending;
                state_next = ptd_pkg::ST_IDLE;
            end
            default:
                state_next = ptd_pkg::ST_IDLE;
        endcase
    end

endmodule

### design/ptd_datapath.sv
// Task tables, tick counter, due check and result register.
module ptd_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        cmd,
    input  logic [7:0]        task_id,
    input  logic [31:0]       period,
    input  ptd_pkg::dp_ctrl_t ctrl,
    output ptd_pkg::dp_stat_t stat,
    output logic              result_strobe,
    output logic              kind,
    output logic [7:0]        dispatch_task,
    output logic              status,
    output logic              last
);

    logic [31:0] period_mem   [ptd_pkg::TASK_SLOTS];
    logic [31:0] last_run_mem [ptd_pkg::TASK_SLOTS];

    logic [31:0]                    tick_count_reg;
    logic [ptd_pkg::TASK_SLOTS-1:0] used_reg;
    logic [ptd_pkg::TASK_SLOTS-1:0] running_reg;
    logic [31:0]                    per_rd_reg;
    logic [31:0]                    lr_rd_reg;
    logic [ptd_pkg::SLOT_W-1:0]     eval_idx_reg;
    logic                           eval_cand_reg;
    logic [ptd_pkg::CNT_W-1:0]      disp_cnt_reg;
    logic                           pend_valid_reg;
    logic [ptd_pkg::SLOT_W-1:0]     pend_idx_reg;
    logic                           strobe_reg, strobe_next;
    logic                           kind_reg, kind_next;
    logic [7:0]                     task_reg, task_next;
    logic                           status_reg, status_next;
    logic                           last_reg, last_next;

    logic                       in_range;
    logic [ptd_pkg::SLOT_W-1:0] cmd_slot;
    logic                       add_we;
    logic [31:0]                elapsed;
    logic                       due;
    logic                       lr_we;
    logic [ptd_pkg::SLOT_W-1:0] lr_waddr;
    logic [31:0]                lr_wdata;

    assign in_range = ({1'b0, task_id} < 9'(ptd_pkg::TASK_SLOTS));
    assign cmd_slot = task_id[ptd_pkg::SLOT_W-1:0];
    assign add_we   = ctrl.do_cmd && in_range && (cmd == ptd_pkg::CMD_ADD);

    // modular elapsed time
    assign elapsed = tick_count_reg - lr_rd_reg;
    assign due     = eval_cand_reg && (elapsed >= per_rd_reg)
                     && (disp_cnt_reg < ptd_pkg::CNT_W'(ptd_pkg::MAX_RESULTS));

    assign lr_we    = due || add_we;
    assign lr_waddr = due ? eval_idx_reg : cmd_slot;
    assign lr_wdata = due ? tick_count_reg : 32'd0;

    assign stat.pending = pend_valid_reg;

    always_ff @(posedge clk)
    begin
        if (add_we)
            period_mem[cmd_slot] <= period;
        if (lr_we)
            last_run_mem[lr_waddr] <= lr_wdata;
        if (ctrl.rd_en)
        begin
            per_rd_reg   <= period_mem[ctrl.rd_addr];
            lr_rd_reg    <= last_run_mem[ctrl.rd_addr];
            eval_idx_reg <= ctrl.rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            used_reg       <= '0;
            running_reg    <= '0;
            eval_cand_reg  <= 1'b0;
            disp_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg    <= strobe_next;
            eval_cand_reg <= ctrl.rd_en && used_reg[ctrl.rd_addr]
                             && running_reg[ctrl.rd_addr];
            if (ctrl.do_tick)
            begin
                tick_count_reg <= tick_count_reg + 32'd1;
                disp_cnt_reg   <= '0;
            end
            else if (due)
                disp_cnt_reg <= disp_cnt_reg + ptd_pkg::CNT_W'(1);
            if (ctrl.do_cmd && in_range)
            begin
                case (cmd)
                    ptd_pkg::CMD_ADD:
                    begin
                        used_reg[cmd_slot]    <= 1'b1;
                        running_reg[cmd_slot] <= 1'b1;
                    end
                    ptd_pkg::CMD_SUSPEND:
                        running_reg[cmd_slot] <= 1'b0;
                    ptd_pkg::CMD_RESUME:
                        running_reg[cmd_slot] <= 1'b1;
                    default:
                        ;
                endcase
            end
            if (due)
                pend_valid_reg <= 1'b1;
            else if (ctrl.flush)
                pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (due)
            pend_idx_reg <= eval_idx_reg;
        if (strobe_next)
        begin
            kind_reg   <= kind_next;
            task_reg   <= task_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    // One dispatch is held back so the final one can carry last.
    always_comb
    begin
        strobe_next = 1'b0;
        kind_next   = ptd_pkg::KIND_DISPATCH;
        task_next   = 8'(pend_idx_reg);
        status_next = ptd_pkg::STATUS_OK;
        last_next   = 1'b0;
        if (ctrl.do_cmd)
        begin
            strobe_next = 1'b1;
            kind_next   = ptd_pkg::KIND_STATUS;
            task_next   = task_id;
            status_next = in_range ? ptd_pkg::STATUS_OK : ptd_pkg::STATUS_BAD_ID;
            last_next   = 1'b1;
        end
        else if (due && pend_valid_reg)
            strobe_next = 1'b1;
        else if (ctrl.flush)
        begin
            strobe_next = 1'b1;
            last_next   = 1'b1;
        end
    end

    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign dispatch_task = task_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule

### design/periodic_task_dispatcher_top.sv
// Top level of the periodic task dispatcher.
// Add, suspend and resume: status result in the cycle after accept; busy stays low.
// Tick: busy while the slot table is scanned (one slot table read per cycle), then
// during drain and flush; dispatches follow from the scan, the final one with last set
// in the first cycle with busy low.
// Reset (async, active low) clears the tick counter and all used/running marks.
`include "periodic_task_dispatcher_top_defines.svh"

module periodic_task_dispatcher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  task_id,
    input  logic [31:0] period,
    output logic        result_strobe,
    output logic        kind,
    output logic [7:0]  dispatch_task,
    output logic        status,
    output logic        last
);

    ptd_pkg::dp_ctrl_t ctrl;
    ptd_pkg::dp_stat_t stat;

    ptd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    ptd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .task_id       (task_id),
        .period        (period),
        .ctrl          (ctrl),
        .stat          (stat),
        .result_strobe (result_strobe),
        .kind          (kind),
        .dispatch_task (dispatch_task),
        .status        (status),
        .last          (last)
    );

    `PTD_ASSERT_NEXT(a_tick_busy, clk, rst_n,
        start && !busy && (cmd == ptd_pkg::CMD_TICK), busy)
    `PTD_ASSERT_NEXT(a_cmd_status, clk, rst_n,
        start && !busy && (cmd != ptd_pkg::CMD_TICK),
        result_strobe && (kind == ptd_pkg::KIND_STATUS) && last)
    `PTD_ASSERT_IMPLY(a_status_last, clk, rst_n,
        result_strobe && (kind == ptd_pkg::KIND_STATUS), last)
    `PTD_ASSERT_IMPLY(a_mid_scan, clk, rst_n,
        result_strobe && !last, busy && (kind == ptd_pkg::KIND_DISPATCH))

endmodule
